>>> sv/kms_pkg.sv
// kms_pkg: shared constants, types and helpers for the k-mer minimizer search
`default_nettype none

package kms_pkg;

	localparam int MAX_K   = 32;
	localparam int MAX_M   = 16;
	localparam int NUC_W   = 2;
	localparam int KMER_W  = NUC_W * MAX_K;
	localparam int LEN_W   = 6;
	localparam int CFG_W   = 5;
	localparam int MIN_W   = NUC_W * MAX_M;
	localparam int OFF_W   = 5;
	localparam int M_RESET = 8;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	function automatic logic [CFG_W-1:0] clamp_m(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0)
			r = CFG_W'(1);
		else if (v > CFG_W'(MAX_M))
			r = CFG_W'(MAX_M);
		return r;
	endfunction

	function automatic logic [MIN_W-1:0] window_mask(input logic [CFG_W-1:0] m);
		logic [MIN_W-1:0] r;
		r = '0;
		for (int i = 0; i < MAX_M; i++) begin
			if (CFG_W'(i) < m)
				r[NUC_W*i +: NUC_W] = '1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/kms_if.sv
// kms_kmer_if / kms_result_if: valid-ready channels for k-mers and results
`default_nettype none

interface kms_kmer_if;
	logic                            valid;
	logic                            ready;
	logic [kms_pkg::KMER_W-1:0]      kmer_bits;
	logic [kms_pkg::LEN_W-1:0]       kmer_length;

	modport source (output valid, output kmer_bits, output kmer_length, input ready);
	modport sink   (input valid, input kmer_bits, input kmer_length, output ready);
endinterface

interface kms_result_if;
	logic                            valid;
	logic                            ready;
	logic [kms_pkg::MIN_W-1:0]       minimizer_value;
	logic [kms_pkg::OFF_W-1:0]       minimizer_offset;
	logic                            too_short;

	modport source (output valid, output minimizer_value, output minimizer_offset,
		output too_short, input ready);
	modport sink   (input valid, input minimizer_value, input minimizer_offset,
		input too_short, output ready);
endinterface

`default_nettype wire

>>> sv/kms_cell.sv
// kms_cell: one nucleotide cell of the shift chain
`default_nettype none

module kms_cell (
	input  wire                          clk,
	input  wire  kms_pkg::cell_ctrl_t    ctrl,
	input  wire  [kms_pkg::NUC_W-1:0]    load_d,
	input  wire  [kms_pkg::NUC_W-1:0]    shift_d,
	output logic [kms_pkg::NUC_W-1:0]    q
);

	logic [kms_pkg::NUC_W-1:0] nuc_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			nuc_q <= load_d;
		end else if (ctrl.shift) begin
			nuc_q <= shift_d;
		end
	end

	assign q = nuc_q;

endmodule

`default_nettype wire

>>> sv/kmer_minimizer_search.sv
// kmer_minimizer_search: forward minimizer search over one k-mer per request
//
// kmer channel: a request carries kmer_bits (two bits per nucleotide, last
// nucleotide in bits 1:0) and kmer_length k. result channel: one result per
// request with minimizer_value, minimizer_offset and too_short.
// cfg_wr_en/cfg_wr_data write m, the window length (reset 8, 0 taken as 1,
// above 16 taken as 16); write only while no request is in flight.
// A loaded k-mer sits in a row of 32 nucleotide cells that shifts one
// nucleotide right per cycle; the low m cells form the window compared
// against the running minimum, one window per cycle.
// A request scans its windows from offset k-m down to 0 and its result is
// registered with the last window; a request with k < m skips the scan
// and returns its too_short result from the wait state. A new request is
// taken only in idle, once the scan of the previous one is through.
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver stalls and a second result is finished,
// the search holds it and takes no request until the output frees.
// Reset clears the control state, empties the output and sets m to 8.
`default_nettype none

module kmer_minimizer_search (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_wr_en,
	input  wire  [kms_pkg::CFG_W-1:0]          cfg_wr_data,
	kms_kmer_if.sink                           kmer,
	kms_result_if.source                       result
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	state_t                          state_q;
	logic [kms_pkg::CFG_W-1:0]       m_q;
	logic [kms_pkg::MIN_W-1:0]       mask_q;
	logic [kms_pkg::MIN_W-1:0]       best_q;
	logic [kms_pkg::OFF_W-1:0]       off_q;
	logic [kms_pkg::OFF_W-1:0]       cnt_q;
	logic [kms_pkg::OFF_W-1:0]       last_q;
	logic                            short_q;

	logic                            out_valid_q;
	logic [kms_pkg::MIN_W-1:0]       out_value_q;
	logic [kms_pkg::OFF_W-1:0]       out_off_q;
	logic                            out_short_q;

	logic                            accept;
	logic                            slot_free;
	logic                            load_out;
	logic [kms_pkg::MIN_W-1:0]       out_value_d;
	logic [kms_pkg::OFF_W-1:0]       out_off_d;
	logic [kms_pkg::LEN_W-1:0]       k_eff;
	logic                            k_short;
	logic [kms_pkg::MIN_W-1:0]       win_raw;
	logic [kms_pkg::MIN_W-1:0]       cand;
	logic                            take;
	logic [kms_pkg::MIN_W-1:0]       best_nx;
	logic [kms_pkg::OFF_W-1:0]       off_nx;
	logic                            scan_last;
	kms_pkg::cell_ctrl_t             cell_ctrl;
	logic [kms_pkg::NUC_W-1:0]       cell_q [kms_pkg::MAX_K];

	assign accept    = kmer.valid && kmer.ready;
	assign slot_free = !out_valid_q || result.ready;
	assign kmer.ready = (state_q == ST_IDLE);

	// cell chain
	assign cell_ctrl.load  = accept;
	assign cell_ctrl.shift = (state_q == ST_SCAN);

	for (genvar i = 0; i < kms_pkg::MAX_K; i++) begin : g_cell
		logic [kms_pkg::NUC_W-1:0] shift_d;
		if (i == kms_pkg::MAX_K - 1) begin : g_end
			assign shift_d = '0;
		end else begin : g_mid
			assign shift_d = cell_q[i+1];
		end
		kms_cell u_cell (
			.clk     (clk),
			.ctrl    (cell_ctrl),
			.load_d  (kmer.kmer_bits[kms_pkg::NUC_W*i +: kms_pkg::NUC_W]),
			.shift_d (shift_d),
			.q       (cell_q[i])
		);
	end

	for (genvar i = 0; i < kms_pkg::MAX_M; i++) begin : g_win
		assign win_raw[kms_pkg::NUC_W*i +: kms_pkg::NUC_W] = cell_q[i];
	end

	// request decode
	always_comb begin
		k_eff = kmer.kmer_length;
		if (kmer.kmer_length > kms_pkg::LEN_W'(kms_pkg::MAX_K))
			k_eff = kms_pkg::LEN_W'(kms_pkg::MAX_K);
		k_short = k_eff < {1'b0, m_q};
	end

	// window compare, later windows lie further left so ties replace
	always_comb begin
		cand      = win_raw & mask_q;
		take      = cand <= best_q;
		best_nx   = take ? cand : best_q;
		off_nx    = take ? (last_q - cnt_q) : off_q;
		scan_last = (cnt_q == last_q);
	end

	always_comb begin
		load_out    = 1'b0;
		out_value_d = best_q;
		out_off_d   = off_q;
		case (state_q)
			ST_SCAN: begin
				load_out    = scan_last && slot_free;
				out_value_d = best_nx;
				out_off_d   = off_nx;
			end
			ST_WAIT: begin
				load_out = slot_free;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q    <= kms_pkg::CFG_W'(kms_pkg::M_RESET);
			mask_q <= kms_pkg::window_mask(kms_pkg::CFG_W'(kms_pkg::M_RESET));
		end else if (cfg_wr_en) begin
			m_q    <= kms_pkg::clamp_m(cfg_wr_data);
			mask_q <= kms_pkg::window_mask(kms_pkg::clamp_m(cfg_wr_data));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			last_q  <= '0;
			short_q <= 1'b0;
			best_q  <= '0;
			off_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						last_q  <= kms_pkg::OFF_W'(k_eff - {1'b0, m_q});
						short_q <= k_short;
						off_q   <= '0;
						if (k_short) begin
							best_q  <= '0;
							state_q <= ST_WAIT;
						end else begin
							best_q  <= '1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					best_q <= best_nx;
					off_q  <= off_nx;
					cnt_q  <= cnt_q + kms_pkg::OFF_W'(1);
					if (scan_last)
						state_q <= slot_free ? ST_IDLE : ST_WAIT;
				end
				ST_WAIT: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= out_value_d;
			out_off_q   <= out_off_d;
			out_short_q <= short_q;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.minimizer_value  = out_value_q;
	assign result.minimizer_offset = out_off_q;
	assign result.too_short        = out_short_q;

`ifndef NO_ASSERTIONS
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.too_short |->
			result.minimizer_value == '0 && result.minimizer_offset == '0)
		else $error("too_short result with nonzero fields");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q <= last_q)
		else $error("scan counter ran past last window");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !kmer.ready)
		else $error("request taken while previous one in flight");

	a_m_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> m_q != '0 && m_q <= kms_pkg::CFG_W'(kms_pkg::MAX_M))
		else $error("window length out of range after write");
`endif

endmodule

`default_nettype wire
